FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/dsfr_pkg.sv
// ---------------------------------------------------------------------------
// dsfr_pkg
// Codes, types and result layout of the DLE STX frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package dsfr_pkg;

    localparam logic [7:0] DLE = 8'h10;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] ETX = 8'h03;
    localparam logic [7:0] NAK = 8'h15;

    localparam logic [2:0] EV_DATA   = 3'd0;
    localparam logic [2:0] EV_OK     = 3'd1;
    localparam logic [2:0] EV_CHKERR = 3'd2;
    localparam logic [2:0] EV_RETRY  = 3'd3;
    localparam logic [2:0] EV_FAIL   = 3'd4;

    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_HUNT_LIMIT = 1'b1;

    localparam logic [7:0] MAX_LENGTH_RST = 8'd15;
    localparam logic [3:0] HUNT_LIMIT_RST = 4'd10;

    typedef enum logic [4:0] {
        PH_HUNT     = 5'b00001,
        PH_HUNT_DLE = 5'b00010,
        PH_DATA     = 5'b00100,
        PH_DATA_DLE = 5'b01000,
        PH_CHECK    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [8:0] frame_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [7:0] max_length;
        logic [3:0] hunt_limit;
    } t_cfg;

    // push0: first result valid, push1: second result valid too
    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

endpackage

`default_nettype wire

FILE: hdl/dsfr_step.sv
// ---------------------------------------------------------------------------
// dsfr_step
// Input register and per-byte framing state machine.
// ---------------------------------------------------------------------------
`default_nettype none

module dsfr_step (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dsfr_pkg::t_cfg      i_cfg,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [7:0]          i_rx_byte,
    input  wire                 i_timeout,
    input  wire                 i_room2,
    output dsfr_pkg::t_push     o_push,
    output dsfr_pkg::t_result   o_res0,
    output dsfr_pkg::t_result   o_res1
);

    logic             r_in_valid;
    logic [7:0]       r_rx_byte;
    logic             r_timeout;

    dsfr_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_hunt_count, n_hunt_count;
    logic [8:0]       r_payload_count, n_payload_count;
    logic [7:0]       r_xor, n_xor;

    logic             go;
    logic             fin;
    logic [2:0]       fin_ev;
    logic [8:0]       fin_len;
    logic [4:0]       hunt_next;
    logic [4:0]       hunt_lim;

    assign go         = r_in_valid && i_room2;
    assign o_in_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_rx_byte <= i_rx_byte;
            r_timeout <= i_timeout;
        end
    end

    // hunt limit of zero acts as one
    assign hunt_lim  = (i_cfg.hunt_limit == 4'd0) ? 5'd1 : {1'b0, i_cfg.hunt_limit};
    assign hunt_next = {1'b0, r_hunt_count} + 5'd1;

    always_comb begin
        n_phase         = r_phase;
        n_hunt_count    = r_hunt_count;
        n_payload_count = r_payload_count;
        n_xor           = r_xor;
        o_push          = '0;
        o_res0          = '0;
        o_res1          = '0;
        fin             = 1'b0;
        fin_ev          = dsfr_pkg::EV_FAIL;
        fin_len         = '0;

        if (r_timeout) begin
            fin = 1'b1;
        end else begin
            case (r_phase)
                dsfr_pkg::PH_DATA: begin
                    if (r_payload_count > {1'b0, i_cfg.max_length}) begin
                        fin = 1'b1;
                    end else if (r_rx_byte == dsfr_pkg::DLE) begin
                        n_phase = dsfr_pkg::PH_DATA_DLE;
                    end else begin
                        n_payload_count  = r_payload_count + 9'd1;
                        n_xor            = r_xor ^ r_rx_byte;
                        o_push.push0     = 1'b1;
                        o_res0.event_res = dsfr_pkg::EV_DATA;
                        o_res0.data_byte = r_rx_byte;
                        o_res0.last      = 1'b1;
                    end
                end
                dsfr_pkg::PH_DATA_DLE: begin
                    if (r_rx_byte == dsfr_pkg::ETX) begin
                        n_phase = dsfr_pkg::PH_CHECK;
                    end else begin
                        n_phase          = dsfr_pkg::PH_DATA;
                        o_push.push0     = 1'b1;
                        o_res0.event_res = dsfr_pkg::EV_DATA;
                        o_res0.data_byte = dsfr_pkg::DLE;
                        if (r_rx_byte == dsfr_pkg::DLE) begin
                            // stuffed DLE collapses to one
                            n_payload_count = r_payload_count + 9'd1;
                            n_xor           = r_xor ^ dsfr_pkg::DLE;
                            o_res0.last     = 1'b1;
                        end else begin
                            // DLE plus other byte: both kept
                            n_payload_count  = r_payload_count + 9'd2;
                            n_xor            = r_xor ^ dsfr_pkg::DLE ^ r_rx_byte;
                            o_push.push1     = 1'b1;
                            o_res1.event_res = dsfr_pkg::EV_DATA;
                            o_res1.data_byte = r_rx_byte;
                            o_res1.last      = 1'b1;
                        end
                    end
                end
                dsfr_pkg::PH_CHECK: begin
                    fin = 1'b1;
                    if (r_rx_byte == (r_xor ^ dsfr_pkg::ETX)) begin
                        fin_ev  = dsfr_pkg::EV_OK;
                        fin_len = r_payload_count;
                    end else begin
                        fin_ev  = dsfr_pkg::EV_CHKERR;
                    end
                end
                default: begin
                    if (r_phase == dsfr_pkg::PH_HUNT_DLE && r_rx_byte == dsfr_pkg::STX) begin
                        n_phase         = dsfr_pkg::PH_DATA;
                        n_hunt_count    = '0;
                        n_payload_count = '0;
                        n_xor           = '0;
                    end else if (r_phase == dsfr_pkg::PH_HUNT_DLE &&
                                 r_rx_byte == dsfr_pkg::NAK) begin
                        fin    = 1'b1;
                        fin_ev = dsfr_pkg::EV_RETRY;
                    end else begin
                        n_phase = (r_rx_byte == dsfr_pkg::DLE) ? dsfr_pkg::PH_HUNT_DLE
                                                               : dsfr_pkg::PH_HUNT;
                        if (hunt_next >= hunt_lim) begin
                            fin = 1'b1;
                        end else begin
                            n_hunt_count = hunt_next[3:0];
                        end
                    end
                end
            endcase
        end

        if (fin) begin
            o_push              = '0;
            o_push.push0        = 1'b1;
            o_res0              = '0;
            o_res0.event_res    = fin_ev;
            o_res0.frame_length = fin_len;
            o_res0.last         = 1'b1;
            n_phase             = dsfr_pkg::PH_HUNT;
            n_hunt_count        = '0;
            n_payload_count     = '0;
            n_xor               = '0;
        end

        // results only land when the held byte is actually processed
        if (!go) begin
            o_push = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= dsfr_pkg::PH_HUNT;
            r_hunt_count    <= '0;
            r_payload_count <= '0;
            r_xor           <= '0;
        end else if (go) begin
            r_phase         <= n_phase;
            r_hunt_count    <= n_hunt_count;
            r_payload_count <= n_payload_count;
            r_xor           <= n_xor;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dsfr_outq.sv
// ---------------------------------------------------------------------------
// dsfr_outq
// Small result queue: takes up to two results a cycle, delivers one.
// ---------------------------------------------------------------------------
`default_nettype none

module dsfr_outq #(
    parameter int DEPTH = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  dsfr_pkg::t_push     i_push,
    input  dsfr_pkg::t_result   i_res0,
    input  dsfr_pkg::t_result   i_res1,
    output logic                o_room2,
    output logic                o_valid,
    input  wire                 i_ready,
    output dsfr_pkg::t_result   o_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM2_MAX = CW'(DEPTH - 2);

    dsfr_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr, r_rd, n_wr;
    logic [PW-1:0]     wr1, wr2;
    logic [CW-1:0]     r_count, n_count;
    logic              pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
    endfunction

    assign wr1     = ptr_inc(r_wr);
    assign wr2     = ptr_inc(wr1);
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign o_room2 = (r_count <= ROOM2_MAX);

    always_comb begin
        n_wr    = r_wr;
        n_count = r_count - CW'(pop);
        if (i_push.push1) begin
            n_wr    = wr2;
            n_count = n_count + CW'(2);
        end else if (i_push.push0) begin
            n_wr    = wr1;
            n_count = n_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_count <= n_count;
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[wr1] <= i_res1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dle_stx_frame_receiver.sv
// ---------------------------------------------------------------------------
// dle_stx_frame_receiver
// DLE STX / DLE ETX frame receiver with XOR block check.
// ---------------------------------------------------------------------------
// Takes one received byte per beat with a timeout flag and returns payload
// bytes (DLE DLE destuffed), then frame ok with length, check error, retry on
// DLE NAK or failure. A byte is taken every cycle as long as the result queue
// has room for two results: each byte is held in the input register, the
// framing state updates from it and its results are written into the queue,
// from which they are delivered. Results leave at one per cycle while the
// consumer is ready; a byte that yields two payload results has them leave
// one after the other. Config writes are taken any time the block is idle.
`default_nettype none
`include "assert_macros.svh"

module dle_stx_frame_receiver #(
    parameter int P_OUT_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_timeout,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic [8:0]  o_frame_length,
    output logic        o_last
);

    dsfr_pkg::t_cfg    r_cfg;
    dsfr_pkg::t_push   push;
    dsfr_pkg::t_result res0, res1, res_out;
    logic              room2;
    logic              pair_open;
    logic              ctrl_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_length <= dsfr_pkg::MAX_LENGTH_RST;
            r_cfg.hunt_limit <= dsfr_pkg::HUNT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsfr_pkg::REG_MAX_LENGTH: r_cfg.max_length <= i_cfg_data;
                dsfr_pkg::REG_HUNT_LIMIT: r_cfg.hunt_limit <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    dsfr_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_timeout  (i_timeout),
        .i_room2    (room2),
        .o_push     (push),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    dsfr_outq #(
        .DEPTH (P_OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res_out)
    );

    assign o_event_res    = res_out.event_res;
    assign o_data_byte    = res_out.data_byte;
    assign o_frame_length = res_out.frame_length;
    assign o_last         = res_out.last;

    assign pair_open = o_out_valid && i_out_ready && !o_last;
    assign ctrl_beat = o_out_valid && (o_event_res != dsfr_pkg::EV_DATA);

    // nothing comes out right after reset
    `ASSERT_ALWAYS(a_idle_after_reset, i_clk, $past(!i_rst_n) |-> !o_out_valid)
    // first of a pair is always followed by its payload partner
    `ASSERT_CLK(a_pair_follows, i_clk, i_rst_n, pair_open |=> (o_out_valid && !ctrl_beat))
    // only payload beats carry a data byte
    `ASSERT_CLK(a_data_only_payload, i_clk, i_rst_n, ctrl_beat |-> (o_data_byte == 8'd0))

endmodule

`default_nettype wire
